>>> hdl/tempo_synced_sine_lfo_unit_macros.svh
// ---------------------------------------------------------------------------
// Tempo-synced sine LFO assertion macros
// Concurrent check wrappers shared by the LFO modules; they compile away
// when NO_ASSERTIONS is defined.
// ---------------------------------------------------------------------------
`ifndef TEMPO_SYNCED_SINE_LFO_UNIT_MACROS_SVH
`define TEMPO_SYNCED_SINE_LFO_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked only while the block is out of reset.
`define TSLFO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every clock edge, reset included.
`define TSLFO_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TSLFO_ASSERT(lbl, prop, msg)
`define TSLFO_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> hdl/tslfo_pkg.sv
// ---------------------------------------------------------------------------
// Tempo-synced sine LFO package
// Widths, register indexes, reset values, the quarter-wave sine table and
// the request and response structs of the shared divider.
// ---------------------------------------------------------------------------
package tslfo_pkg;

  localparam int SINE_TABLE_BITS = 10;
  localparam int OUTPUT_BITS     = 16;
  localparam int QUARTER_LEN     = 1 << (SINE_TABLE_BITS - 2);
  localparam int QIDX_W          = SINE_TABLE_BITS - 1;
  localparam int MAG_W           = 15;
  localparam int AMP_W           = 15;
  localparam int PROD_W          = MAG_W + AMP_W;
  localparam int GAIN_SHIFT      = 31 - OUTPUT_BITS;
  localparam int PHASE_W         = 32;
  localparam int POS_W           = 40;
  localparam int OFFSET_W        = 16;
  localparam int RATIO_W         = 4;
  localparam int DVD_W           = 64;
  localparam int QUO_W           = 34;
  localparam int DIV_STEP_W      = 7;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 32;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Phase advance of one sample in Q24.8.
  localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(256);

  // Divide lengths, one quotient bit per cycle.
  localparam logic [DIV_STEP_W-1:0] STEPS_PERIOD = DIV_STEP_W'(34);
  localparam logic [DIV_STEP_W-1:0] STEPS_SYNC   = DIV_STEP_W'(48);
  localparam logic [DIV_STEP_W-1:0] STEPS_ANGLE  = DIV_STEP_W'(64);

  // Operation codes of the input beat.
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SYNC = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_HOST_CLOCKED     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BEAT_RATIO       = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_BEAT = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_FREE_WAVELENGTH  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE        = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_OFFSET     = CFG_IDX_W'(5);

  // Reset values of the configuration registers.
  localparam logic                RST_HOST_CLOCKED     = 1'b0;
  localparam logic [RATIO_W-1:0]  RST_BEAT_RATIO       = RATIO_W'(2);
  localparam logic [31:0]         RST_SAMPLES_PER_BEAT = 32'd5644800;
  localparam logic [31:0]         RST_FREE_WAVELENGTH  = 32'd12288000;
  localparam logic [AMP_W-1:0]    RST_AMPLITUDE        = AMP_W'(32767);
  localparam logic [OFFSET_W-1:0] RST_PHASE_OFFSET     = OFFSET_W'(0);

  typedef logic [MAG_W-1:0] qtab_t [0:QUARTER_LEN];

  typedef struct packed {
    logic                  start;
    logic [DVD_W-1:0]      dividend;
    logic [31:0]           divisor;
    logic [DIV_STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
    logic [31:0]      remainder;
  } div_rsp_t;

  // One quarter-wave entry: Taylor series of sin to x^15 in Q2.30, every
  // term truncated, then scaled to Q1.15 with rounding.
  function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned i);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] v;
    longint      sum;
    begin
      x    = (64'(i) * HALF_PI_Q30) / QUARTER_LEN;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      term = ((term * x2) >> 30) / 6;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 20;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 42;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 72;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 110;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 156;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 210;
      sum  = sum - longint'(term);
      if (sum < 0) begin
        sum = 0;
      end
      v = (64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      return v[MAG_W-1:0];
    end
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t t;
    begin
      for (int i = 0; i <= QUARTER_LEN; i++) begin
        t[i] = quarter_sine(i);
      end
      return t;
    end
  endfunction

  localparam qtab_t QUARTER_SINE = build_qtab();

  // Beat ratio numerator and denominator; codes past ten act as one beat.
  function automatic logic [1:0] ratio_num(input logic [RATIO_W-1:0] r);
    case (r)
      4'd0:    return 2'd2;
      4'd1:    return 2'd3;
      4'd3:    return 2'd3;
      4'd4:    return 2'd2;
      default: return 2'd1;
    endcase
  endfunction

  function automatic logic [4:0] ratio_den(input logic [RATIO_W-1:0] r);
    case (r)
      4'd1:    return 5'd2;
      4'd3:    return 5'd4;
      4'd4:    return 5'd3;
      4'd5:    return 5'd2;
      4'd6:    return 5'd3;
      4'd7:    return 5'd4;
      4'd8:    return 5'd6;
      4'd9:    return 5'd8;
      4'd10:   return 5'd16;
      default: return 5'd1;
    endcase
  endfunction

endpackage

>>> hdl/tslfo_div.sv
// ---------------------------------------------------------------------------
// Tempo-synced sine LFO shared divider
// Restoring divider, one quotient bit per cycle, with a left-aligned
// dividend and a programmable number of steps.
// ---------------------------------------------------------------------------
`include "tempo_synced_sine_lfo_unit_macros.svh"

module tslfo_div
  import tslfo_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                  busy_r;
  logic                  done_r;
  logic [DIV_STEP_W-1:0] cnt_r;
  logic [DVD_W-1:0]      dvd_r;
  logic [31:0]           dsr_r;
  logic [31:0]           rem_r;
  logic [QUO_W-1:0]      quo_r;

  logic [32:0] trial;
  logic        ge;
  logic [31:0] rem_nxt;

  // The partial remainder always stays below the divisor, so the trial
  // value fits in 33 bits and the difference in 32.
  always_comb begin
    trial   = {rem_r, dvd_r[DVD_W-1]};
    ge      = trial >= {1'b0, dsr_r};
    rem_nxt = ge ? 32'(trial - {1'b0, dsr_r}) : trial[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      dsr_r <= req.divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      quo_r <= {quo_r[QUO_W-2:0], ge};
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

  `TSLFO_ASSERT(a_div_no_restart, req.start |-> !busy_r, "divider restarted while busy")
  `TSLFO_ASSERT(a_div_done_after_run, done_r |-> ($past(busy_r) && !busy_r),
                "divider done without a finished run")

endmodule

>>> hdl/tslfo_shape.sv
// ---------------------------------------------------------------------------
// Tempo-synced sine LFO wave shaper
// Adds the phase offset to the angle, looks up the quarter-wave table,
// applies the amplitude gain with rounding and restores the sign.
// ---------------------------------------------------------------------------
`include "tempo_synced_sine_lfo_unit_macros.svh"

module tslfo_shape
  import tslfo_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [PHASE_W-1:0]            angle,
  input  logic [OFFSET_W-1:0]           offset,
  input  logic [AMP_W-1:0]              amplitude,
  output logic                          done,
  output logic signed [OUTPUT_BITS-1:0] value
);

  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (GAIN_SHIFT - 1);

  logic [PHASE_W-1:0]         angle_sum;
  logic [SINE_TABLE_BITS-1:0] index;
  logic [1:0]                 quad;
  logic [QIDX_W-1:0]          pos_ext;
  logic [QIDX_W-1:0]          tidx;
  logic [PROD_W-1:0]          rnd_sum;
  logic [OUTPUT_BITS-1:0]     mag_ext;

  logic                   v1_r;
  logic                   v2_r;
  logic                   v3_r;
  logic [MAG_W-1:0]       mag_r;
  logic                   neg1_r;
  logic                   neg2_r;
  logic [PROD_W-1:0]      prod_r;
  logic [OUTPUT_BITS-1:0] val_r;

  // Odd quadrants read the table mirrored; the upper half-wave is negated.
  always_comb begin
    angle_sum = angle + {offset, 16'b0};
    index     = angle_sum[PHASE_W-1 -: SINE_TABLE_BITS];
    quad      = index[SINE_TABLE_BITS-1 -: 2];
    pos_ext   = {1'b0, index[SINE_TABLE_BITS-3:0]};
    tidx      = quad[0] ? QIDX_W'(QUARTER_LEN) - pos_ext : pos_ext;
    rnd_sum   = prod_r + ROUND_HALF;
    mag_ext   = {1'b0, rnd_sum[PROD_W-1:GAIN_SHIFT]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag_r  <= QUARTER_SINE[tidx];
      neg1_r <= quad[1];
    end
    if (v1_r) begin
      prod_r <= PROD_W'(mag_r) * PROD_W'(amplitude);
      neg2_r <= neg1_r;
    end
    if (v2_r) begin
      val_r <= neg2_r ? OUTPUT_BITS'(-mag_ext) : mag_ext;
    end
  end

  assign done  = v3_r;
  assign value = signed'(val_r);

  `TSLFO_ASSERT(a_shape_latency, start |-> ##3 v3_r, "shaper result not ready three cycles on")

endmodule

>>> hdl/tempo_synced_sine_lfo_unit.sv
// ---------------------------------------------------------------------------
// Tempo-synced sine LFO
// Top level: configuration registers, phase counter and the sequencer that
// drives the shared divider and the wave shaper.
// ---------------------------------------------------------------------------
// Usage. The input channel (in_valid / in_stall) carries one beat per
// operation: a tick outputs the current sine value and advances the phase by
// one sample; a sync, in host-clocked mode, first sets the phase to the host
// sample position modulo the period. Every input beat yields exactly one
// beat on the output channel (out_valid / out_stall) carrying out_lfo_value.
// The block works on one beat at a time. Its pace is set by the shared
// restoring divider, which makes one quotient bit per cycle for the
// beat-ratio period, the sync position modulo and the phase-to-angle
// fraction.
// in_stall is high from acceptance until the result has been loaded into the
// output register, so the next beat can be taken while that result still
// waits on a stalled receiver. A stalled output beat holds its value.
// Reset (rst_n low, synchronous) clears the phase, empties the output and
// loads the configuration defaults. Configuration writes (cfg_we,
// cfg_index, cfg_data) take effect at once and belong to idle periods.
// ---------------------------------------------------------------------------
`include "tempo_synced_sine_lfo_unit_macros.svh"

module tempo_synced_sine_lfo_unit
  import tslfo_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_operation,
  input  logic [POS_W-1:0]              in_sample_pos,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [OUTPUT_BITS-1:0] out_lfo_value,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  // Sequencer states.
  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_PER_GO   = 4'd1;
  localparam logic [3:0] ST_PER_WAIT = 4'd2;
  localparam logic [3:0] ST_DECIDE   = 4'd3;
  localparam logic [3:0] ST_MOD_GO   = 4'd4;
  localparam logic [3:0] ST_MOD_WAIT = 4'd5;
  localparam logic [3:0] ST_ANG_GO   = 4'd6;
  localparam logic [3:0] ST_ANG_WAIT = 4'd7;
  localparam logic [3:0] ST_SHP_WAIT = 4'd8;
  localparam logic [3:0] ST_OUT      = 4'd9;

  // Configuration registers.
  logic                host_clocked_r;
  logic [RATIO_W-1:0]  beat_ratio_r;
  logic [31:0]         samples_per_beat_r;
  logic [31:0]         free_wavelength_r;
  logic [AMP_W-1:0]    amplitude_r;
  logic [OFFSET_W-1:0] phase_offset_r;

  // Sequencer and working state.
  logic [3:0]             state_r;
  logic [3:0]             state_nxt;
  logic [PHASE_W-1:0]     phase_r;
  logic [PHASE_W-1:0]     period_r;
  logic                   op_r;
  logic [POS_W-1:0]       pos_r;
  logic                   out_valid_r;
  logic [OUTPUT_BITS-1:0] out_value_r;

  div_req_t               div_req;
  div_rsp_t               div_rsp;
  logic                   shp_start;
  logic [PHASE_W-1:0]     shp_angle;
  logic                   shp_done;
  logic signed [OUTPUT_BITS-1:0] shp_value;

  logic [1:0]         num;
  logic [4:0]         den;
  logic [QUO_W-1:0]   per_dvd;
  logic [PHASE_W-1:0] per_sat;
  logic [PHASE_W:0]   phase_adv;
  logic               out_free;
  logic               in_take;

  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Beat-ratio period: samples_per_beat times a numerator of one to three
  // is a shift and an add; the denominator goes through the divider.
  always_comb begin
    num       = ratio_num(beat_ratio_r);
    den       = ratio_den(beat_ratio_r);
    per_dvd   = (num[1] ? {1'b0, samples_per_beat_r, 1'b0} : '0) +
                (num[0] ? {2'b0, samples_per_beat_r} : '0);
    per_sat   = (div_rsp.quotient[QUO_W-1:PHASE_W] != '0) ? '1
                : div_rsp.quotient[PHASE_W-1:0];
    phase_adv = {1'b0, phase_r} + {1'b0, PHASE_ONE};
  end

  always_comb begin
    state_nxt = state_r;
    div_req   = '0;
    shp_start = 1'b0;
    shp_angle = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = host_clocked_r ? ST_PER_GO : ST_DECIDE;
        end
      end
      ST_PER_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = {per_dvd, {(DVD_W - QUO_W){1'b0}}};
        div_req.divisor  = {27'b0, den};
        div_req.steps    = STEPS_PERIOD;
        state_nxt        = ST_PER_WAIT;
      end
      ST_PER_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (op_r == OP_SYNC && host_clocked_r && period_r != '0) begin
          state_nxt = ST_MOD_GO;
        end else begin
          state_nxt = ST_ANG_GO;
        end
      end
      ST_MOD_GO: begin
        // Position in whole samples, moved to Q24.8 and left-aligned.
        div_req.start    = 1'b1;
        div_req.dividend = {pos_r, {(DVD_W - POS_W){1'b0}}};
        div_req.divisor  = period_r;
        div_req.steps    = STEPS_SYNC;
        state_nxt        = ST_MOD_WAIT;
      end
      ST_MOD_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = ST_ANG_GO;
        end
      end
      ST_ANG_GO: begin
        if (period_r == '0) begin
          // A zero period gives a zero angle fraction.
          shp_start = 1'b1;
          state_nxt = ST_SHP_WAIT;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = {phase_r, {(DVD_W - PHASE_W){1'b0}}};
          div_req.divisor  = period_r;
          div_req.steps    = STEPS_ANGLE;
          state_nxt        = ST_ANG_WAIT;
        end
      end
      ST_ANG_WAIT: begin
        if (div_rsp.done) begin
          // Only the low quotient bits matter: the angle wraps once a cycle.
          shp_start = 1'b1;
          shp_angle = div_rsp.quotient[PHASE_W-1:0];
          state_nxt = ST_SHP_WAIT;
        end
      end
      ST_SHP_WAIT: begin
        if (shp_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r            <= ST_IDLE;
      phase_r            <= '0;
      out_valid_r        <= 1'b0;
      host_clocked_r     <= RST_HOST_CLOCKED;
      beat_ratio_r       <= RST_BEAT_RATIO;
      samples_per_beat_r <= RST_SAMPLES_PER_BEAT;
      free_wavelength_r  <= RST_FREE_WAVELENGTH;
      amplitude_r        <= RST_AMPLITUDE;
      phase_offset_r     <= RST_PHASE_OFFSET;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_index)
          CFG_HOST_CLOCKED:     host_clocked_r     <= cfg_data[0];
          CFG_BEAT_RATIO:       beat_ratio_r       <= cfg_data[RATIO_W-1:0];
          CFG_SAMPLES_PER_BEAT: samples_per_beat_r <= cfg_data;
          CFG_FREE_WAVELENGTH:  free_wavelength_r  <= cfg_data;
          CFG_AMPLITUDE:        amplitude_r        <= cfg_data[AMP_W-1:0];
          CFG_PHASE_OFFSET:     phase_offset_r     <= cfg_data[OFFSET_W-1:0];
          default: begin
          end
        endcase
      end

      // A sync against a zero period parks the phase at zero.
      if (state_r == ST_DECIDE && op_r == OP_SYNC && host_clocked_r &&
          period_r == '0) begin
        phase_r <= '0;
      end
      if (state_r == ST_MOD_WAIT && div_rsp.done) begin
        phase_r <= div_rsp.remainder;
      end
      // A tick advances one sample and restarts at zero once the period is
      // reached or passed.
      if (state_r == ST_OUT && out_free && op_r == OP_TICK) begin
        phase_r <= (phase_adv >= {1'b0, period_r}) ? '0 : phase_adv[PHASE_W-1:0];
      end

      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r     <= in_operation;
      pos_r    <= in_sample_pos;
      period_r <= free_wavelength_r;
    end
    if (state_r == ST_PER_WAIT && div_rsp.done) begin
      period_r <= per_sat;
    end
    if (state_r == ST_OUT && out_free) begin
      out_value_r <= shp_value;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_lfo_value = signed'(out_value_r);

  tslfo_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  tslfo_shape u_shape (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (shp_start),
    .angle     (shp_angle),
    .offset    (phase_offset_r),
    .amplitude (amplitude_r),
    .done      (shp_done),
    .value     (shp_value)
  );

  `TSLFO_ASSERT(a_out_loaded, (state_r == ST_OUT && out_free) |=>
                (out_valid_r && state_r == ST_IDLE), "result beat not loaded")
  `TSLFO_ASSERT(a_phase_wrap, (state_r == ST_OUT && out_free && op_r == OP_TICK) |=>
                (phase_r == '0 || phase_r < period_r), "phase left past the period")

endmodule
